/* sv/rnaf_pkg.sv */
`timescale 1ns / 1ps
// Package for the radix number to ASCII formatter.
// Holds payload types, controller/datapath command and status types, and constants.
// No dependencies.
package rnaf_pkg;

  // Default for the maximum number of characters per number.
  localparam int unsigned MAX_DIGITS_DEF = 20;

  // Fixed field widths.
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;

  // The long division handles this many dividend bits per cycle.
  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned CHUNKS    = VALUE_W / STEP_BITS;
  localparam int unsigned CHUNK_W   = $clog2(CHUNKS);

  // Radix limits.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

  // One input item.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [LEN_W-1:0]   min_length;
    logic [CHAR_W-1:0]  pad_char;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // Capture a new input transfer.
    logic step;      // One chunk of the long division.
    logic store;     // Write the finished digit to the buffer.
    logic plan;      // Work out padding and the read pointer.
    logic emit_pad;  // Load a pad character into the output register.
    logic rd_req;    // Read the next digit from the buffer.
    logic emit_dig;  // Load the digit read into the output register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chunk_last;  // The current division chunk is the final one.
    logic more;        // Another digit has to be produced.
    logic pad_zero;    // No pad characters are left.
    logic idx_zero;    // The digit being read is the least significant one.
    logic out_free;    // The output register can take a character this cycle.
  } sts_t;

  // Clamps a raw radix field to the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Lower-case ASCII glyph of a digit value.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_A + CHAR_W'(d) - 8'd10;
    end
    return res;
  endfunction

endpackage

/* sv/rnaf_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rnaf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rnaf_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the radix number to ASCII formatter.
// Depends on rnaf_pkg for the command and status types.
module rnaf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rnaf_pkg::sts_t sts_i,
  output rnaf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_PLAN  = 3'd3;
  localparam logic [2:0] ST_PAD   = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_GET   = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.chunk_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = sts_i.more ? ST_DIV : ST_PLAN;
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = ST_PAD;
      end
      ST_PAD: begin
        if (sts_i.pad_zero) begin
          state_d = ST_RD;
        end else if (sts_i.out_free) begin
          cmd_o.emit_pad = 1'b1;
        end
      end
      ST_RD: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_GET;
      end
      ST_GET: begin
        if (sts_i.out_free) begin
          cmd_o.emit_dig = 1'b1;
          state_d        = sts_i.idx_zero ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new number is taken only between numbers.
  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* sv/rnaf_dp.sv */
`timescale 1ns / 1ps
// Datapath of the radix number to ASCII formatter: divider, digit buffer, output register.
// Depends on rnaf_pkg and rnaf_ram.
module rnaf_dp #(
  parameter int unsigned MAX_DIGITS = rnaf_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rnaf_pkg::in_t  in_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output rnaf_pkg::out_t out_data_o,
  input  rnaf_pkg::cmd_t cmd_i,
  output rnaf_pkg::sts_t sts_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned SB    = rnaf_pkg::STEP_BITS;
  localparam int unsigned VW    = rnaf_pkg::VALUE_W;
  localparam int unsigned DW    = rnaf_pkg::DIGIT_W;
  localparam int unsigned LW    = rnaf_pkg::LEN_W;

  logic [VW-1:0]                    num_q, num_d;
  logic [DW-1:0]                    rem_q, rem_d;
  logic [rnaf_pkg::RADIX_W-1:0]     radix_q;
  logic [LW-1:0]                    minlen_q;
  logic [rnaf_pkg::CHAR_W-1:0]      pad_q;
  logic [rnaf_pkg::CHUNK_W-1:0]     chunk_q;
  logic [CNT_W-1:0]                 ndig_q, ndig_inc;
  logic [CNT_W-1:0]                 npad_q, npad_d;
  logic [IDX_W-1:0]                 idx_q;
  logic                             ovf_q;
  logic                             first_q;
  logic                             out_valid_q;
  rnaf_pkg::out_t                   out_q;
  logic [DW-1:0]                    rd_digit;
  logic                             out_free;
  logic                             num_nz;
  logic [LW-1:0]                    ndig_w;
  logic [LW-1:0]                    total;

  // One chunk of restoring division: STEP_BITS quotient bits, remainder stays narrow.
  always_comb begin
    logic [DW:0]   t;
    logic [SB-1:0] qbits;
    t     = '0;
    qbits = '0;
    rem_d = rem_q;
    for (int k = 0; k < SB; k++) begin
      t = {rem_d, num_q[VW-1-k]};
      if (t >= radix_q) begin
        t              = t - radix_q;
        qbits[SB-1-k]  = 1'b1;
      end
      rem_d = t[DW-1:0];
    end
    num_d = {num_q[VW-SB-1:0], qbits};
  end

  assign num_nz   = (num_q != '0);
  assign ndig_inc = ndig_q + 1'b1;

  // Padding plan: total length is the larger of digits and minimum, capped.
  always_comb begin
    ndig_w = LW'(ndig_q);
    total  = (minlen_q > ndig_w) ? minlen_q : ndig_w;
    if (total > LW'(MAX_DIGITS)) begin
      total = LW'(MAX_DIGITS);
    end
    npad_d = CNT_W'(total - ndig_w);
  end

  // Input capture and division registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q    <= in_data_i.value;
      radix_q  <= rnaf_pkg::clamp_radix(in_data_i.radix);
      minlen_q <= in_data_i.min_length;
      pad_q    <= in_data_i.pad_char;
      rem_q    <= '0;
    end else if (cmd_i.step) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end else if (cmd_i.store) begin
      rem_q <= '0;
    end
  end

  // Digit count, chunk counter, padding count, read pointer and overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      ndig_q  <= '0;
      npad_q  <= '0;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        chunk_q <= '0;
        ndig_q  <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.step) begin
        chunk_q <= chunk_q + 1'b1;
      end
      if (cmd_i.store) begin
        ndig_q <= ndig_inc;
        ovf_q  <= num_nz && !(ndig_inc < CNT_W'(MAX_DIGITS));
      end
      if (cmd_i.plan) begin
        npad_q  <= npad_d;
        idx_q   <= IDX_W'(ndig_q - 1'b1);
        first_q <= 1'b1;
      end
      if (cmd_i.emit_pad) begin
        npad_q <= npad_q - 1'b1;
      end
      if (cmd_i.emit_dig) begin
        idx_q   <= idx_q - 1'b1;
        first_q <= 1'b0;
      end
    end
  end

  // Digit buffer, written least significant first and read back in reverse.
  rnaf_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_DIGITS)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store),
    .waddr_i(ndig_q[IDX_W-1:0]),
    .wdata_i(rem_q),
    .re_i   (cmd_i.rd_req),
    .raddr_i(idx_q),
    .rdata_o(rd_digit)
  );

  // Output register: taken by the sink whenever it does not stall.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pad || cmd_i.emit_dig) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pad) begin
      out_q.char_out <= pad_q;
      out_q.last     <= 1'b0;
    end else if (cmd_i.emit_dig) begin
      out_q.char_out <= (ovf_q && first_q) ? rnaf_pkg::CHAR_QMARK
                                           : rnaf_pkg::glyph(rd_digit);
      out_q.last     <= (idx_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller.
  assign sts_o.chunk_last = (chunk_q == rnaf_pkg::CHUNK_W'(rnaf_pkg::CHUNKS - 1));
  assign sts_o.more       = num_nz && (ndig_inc < CNT_W'(MAX_DIGITS));
  assign sts_o.pad_zero   = (npad_q == '0);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.out_free   = out_free;

  // The digit count never passes the buffer depth.
  a_ndig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

  // An overflow mark only arises with a full buffer.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (ndig_q == CNT_W'(MAX_DIGITS)))
    else $error("overflow flagged with buffer not full");

  // A pad character is only emitted while padding remains.
  a_pad_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pad |-> (npad_q != '0))
    else $error("pad emitted with no padding left");

  // A held, stalled character is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_pad || cmd_i.emit_dig) |-> out_free)
    else $error("output register overwritten while stalled");

  // With overflow there is no padding.
  a_ovf_nopad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && cmd_i.plan) |=> (npad_q == '0))
    else $error("padding planned on overflow");

endmodule

/* sv/radix_number_to_ascii_formatter_unit.sv */
`timescale 1ns / 1ps
// Radix number to ASCII formatter, top level: controller plus datapath.
// Depends on rnaf_pkg, rnaf_ctrl, rnaf_dp (and through it rnaf_ram).
//
// Takes a 64-bit unsigned number, a radix (clamped to 2..16), a minimum length and a pad
// byte, and emits lower-case ASCII characters one per output transfer, pad bytes first,
// then digits most significant first; the final character carries last. At most MAX_DIGITS
// characters come out; if the number needs more, the first character is '?' and the low
// MAX_DIGITS-1 digits follow. One number is worked on at a time. For each digit the divider
// runs over the 64 dividend bits at eight bits per cycle and then writes the buffer; the
// number then takes a planning step, pad characters are emitted straight from the pad
// register and each digit character needs a registered buffer read first. The output
// register lets the next number be accepted while the last character still waits to be
// taken.
module radix_number_to_ascii_formatter_unit #(
  parameter int unsigned MAX_DIGITS = rnaf_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rnaf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rnaf_pkg::out_t out_data_o
);

  rnaf_pkg::cmd_t cmd;
  rnaf_pkg::sts_t sts;

  // Sequencer.
  rnaf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Divider, digit buffer and output register.
  rnaf_dp #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
